/* rtl/core/hpi_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the hash table probe and insert unit.
// Depends on nothing; every module of the block imports it.
package hpi_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [63:0] HASH_MULT = 64'hff51afd7ed558ccd;
	localparam int HASH_SHIFT = 33;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_FOUND = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	typedef enum logic [1:0] {
		KIND_LOOKUP,
		KIND_INSERT,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [63:0] key;
	} req_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_SUM,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_INIT,
		B_IDLE,
		B_PROBE,
		B_CLEAR
	} back_state_t;

	function automatic logic [63:0] xor_shift(input logic [63:0] v);
		return v ^ (v >> HASH_SHIFT);
	endfunction

endpackage

/* rtl/core/hpi_front.sv */
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the operation and computes the home slot.
// Depends on hpi_pkg; feeds hpi_queue.
module hpi_front import hpi_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int SLOT_W = $clog2(TABLE_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        op,
	input  logic [63:0]       search_key,
	input  logic              init_done,
	output logic              push_valid,
	input  logic              push_ready,
	output req_t              push_req,
	output logic [SLOT_W-1:0] push_home
);

	localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam int MOD_BITS = 4;
	localparam int MOD_STEPS = 64 / MOD_BITS;
	localparam int STEP_W = $clog2(MOD_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MOD_STEPS - 1);
	localparam logic [SLOT_W:0] DEPTH_R = (SLOT_W + 1)'(TABLE_DEPTH);

	front_state_t state_q, state_d;
	kind_t kind_dec;
	req_t req_q;
	logic [63:0] mix_q;
	logic [63:0] p_ll_q;
	logic [31:0] p_lh_q;
	logic [31:0] p_hl_q;
	logic [63:0] sum_mix;
	logic [63:0] hash_q;
	logic [SLOT_W-1:0] rem_q;
	logic [SLOT_W-1:0] rem_next;
	logic [SLOT_W:0] rem_work;
	logic [SLOT_W-1:0] home_q;
	logic [STEP_W-1:0] step_q;
	logic accept;

	always_comb begin
		unique case (op)
			OP_LOOKUP: kind_dec = KIND_LOOKUP;
			OP_INSERT: kind_dec = KIND_INSERT;
			OP_CLEAR:  kind_dec = KIND_CLEAR;
			default:   kind_dec = KIND_LOOKUP;
		endcase
	end

	// Low 64 bits of the product, assembled from three partial products of 32-bit halves, then xor-shifted.
	assign sum_mix = xor_shift(p_ll_q + {p_lh_q + p_hl_q, 32'd0});

	// Remainder by the table size, MOD_BITS bits of the hash per cycle, MSB first.
	always_comb begin
		rem_work = {1'b0, rem_q};
		for (int i = 0; i < MOD_BITS; i++) begin
			rem_work = {rem_work[SLOT_W-1:0], hash_q[63-i]};
			if (rem_work >= DEPTH_R) begin
				rem_work = rem_work - DEPTH_R;
			end
		end
		rem_next = rem_work[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				req_ready = init_done;
				if (req_valid && init_done) begin
					state_d = F_MUL;
				end
			end
			F_MUL: state_d = F_SUM;
			F_SUM: state_d = IS_POW2 ? F_PUSH : F_MOD;
			F_MOD: begin
				if (step_q == STEP_LAST) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= '{kind: kind_dec, key: search_key};
			mix_q <= xor_shift(search_key);
		end
		if (state_q == F_MUL) begin
			p_ll_q <= 64'(mix_q[31:0]) * 64'(HASH_MULT[31:0]);
			p_lh_q <= mix_q[31:0] * HASH_MULT[63:32];
			p_hl_q <= mix_q[63:32] * HASH_MULT[31:0];
		end
		if (state_q == F_SUM) begin
			hash_q <= sum_mix;
			rem_q <= '0;
			step_q <= '0;
			if (IS_POW2) begin
				home_q <= sum_mix[SLOT_W-1:0];
			end
		end
		if (state_q == F_MOD) begin
			hash_q <= hash_q << MOD_BITS;
			rem_q <= rem_next;
			step_q <= step_q + 1'b1;
			if (step_q == STEP_LAST) begin
				home_q <= rem_next;
			end
		end
	end

	assign push_req = req_q;
	assign push_home = home_q;

endmodule

/* rtl/core/hpi_queue.sv */
`timescale 1ns / 1ps
// Short request queue between the front end and the probe engine.
// Depends on hpi_pkg for the request type and its depth.
module hpi_queue import hpi_pkg::*; #(
	parameter int SLOT_W = $clog2(TABLE_DEPTH_DEF)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  req_t              push_req,
	input  logic [SLOT_W-1:0] push_home,
	output logic              pop_valid,
	input  logic              pop_ready,
	output req_t              pop_req,
	output logic [SLOT_W-1:0] pop_home
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0] COUNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

	req_t req_mem [QUEUE_DEPTH];
	logic [SLOT_W-1:0] home_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != COUNT_FULL;
	assign pop_valid = count_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_req = req_mem[rd_ptr_q];
	assign pop_home = home_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			req_mem[wr_ptr_q] <= push_req;
			home_mem[wr_ptr_q] <= push_home;
		end
	end

endmodule

/* rtl/core/hpi_back.sv */
`timescale 1ns / 1ps
// Probe engine: owns the slot memories, walks probe chains, inserts and clears.
// Depends on hpi_pkg; takes requests from hpi_queue.
module hpi_back import hpi_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int SLOT_W = $clog2(TABLE_DEPTH),
	localparam int PROBE_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  req_t               pop_req,
	input  logic [SLOT_W-1:0]  pop_home,
	output logic               init_done,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [PROBE_W-1:0] probe_count
);

	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_DEPTH - 1);
	localparam logic [PROBE_W-1:0] PROBE_MAX = PROBE_W'(TABLE_DEPTH);

	back_state_t state_q, state_d;

	logic valid_mem [TABLE_DEPTH];
	logic [63:0] key_mem [TABLE_DEPTH];

	kind_t kind_q;
	logic [63:0] key_q;
	logic [SLOT_W-1:0] idx_q, idx_next;
	logic [PROBE_W-1:0] probes_q, probes_next;
	logic [SLOT_W-1:0] sweep_q;
	logic sweep_last, sweep_step;

	logic [SLOT_W-1:0] rd_addr, wr_addr;
	logic rd_valid_q;
	logic [63:0] rd_key_q;
	logic mem_we, key_we, wr_bit;

	logic out_valid_q;
	logic [2:0] status_q, status_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [PROBE_W-1:0] probes_out_q, probes_d;
	logic load_out, out_free, advance, pop_take, hit;

	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign probes_next = probes_q + 1'b1;
	assign sweep_last = sweep_q == LAST_IDX;
	assign out_free = !out_valid_q || rsp_ready;
	assign pop_take = pop_valid && pop_ready;
	assign hit = rd_valid_q && (rd_key_q == key_q);
	assign init_done = state_q != B_INIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			sweep_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sweep_step) begin
				sweep_q <= sweep_q + 1'b1;
			end else if (state_d != state_q) begin
				sweep_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pop_ready = 1'b0;
		rd_addr = idx_q;
		wr_addr = idx_q;
		mem_we = 1'b0;
		key_we = 1'b0;
		wr_bit = 1'b0;
		load_out = 1'b0;
		status_d = ST_NOT_FOUND;
		slot_d = '0;
		probes_d = probes_q;
		advance = 1'b0;
		sweep_step = 1'b0;
		unique case (state_q)
			B_INIT: begin
				mem_we = 1'b1;
				wr_addr = sweep_q;
				if (sweep_last) begin
					state_d = B_IDLE;
				end else begin
					sweep_step = 1'b1;
				end
			end
			B_IDLE: begin
				pop_ready = 1'b1;
				rd_addr = pop_home;
				if (pop_valid) begin
					state_d = (pop_req.kind == KIND_CLEAR) ? B_CLEAR : B_PROBE;
				end
			end
			B_PROBE: begin
				if (hit) begin
					if (out_free) begin
						load_out = 1'b1;
						status_d = ST_FOUND;
						slot_d = idx_q;
						state_d = B_IDLE;
					end
				end else if (!rd_valid_q) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d = B_IDLE;
						if (kind_q == KIND_INSERT) begin
							mem_we = 1'b1;
							key_we = 1'b1;
							wr_bit = 1'b1;
							status_d = ST_INSERTED;
							slot_d = idx_q;
						end
					end
				end else if (probes_next == PROBE_MAX) begin
					// Every slot holds some other key.
					if (out_free) begin
						load_out = 1'b1;
						status_d = (kind_q == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
						probes_d = probes_next;
						state_d = B_IDLE;
					end
				end else begin
					advance = 1'b1;
					rd_addr = idx_next;
				end
			end
			B_CLEAR: begin
				mem_we = 1'b1;
				wr_addr = sweep_q;
				if (sweep_last) begin
					if (out_free) begin
						load_out = 1'b1;
						status_d = ST_CLEARED;
						probes_d = '0;
						state_d = B_IDLE;
					end
				end else begin
					sweep_step = 1'b1;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop_take) begin
			kind_q <= pop_req.kind;
			key_q <= pop_req.key;
			idx_q <= pop_home;
			probes_q <= '0;
		end else if (advance) begin
			idx_q <= idx_next;
			probes_q <= probes_next;
		end
		if (load_out) begin
			status_q <= status_d;
			slot_q <= slot_d;
			probes_out_q <= probes_d;
		end
	end

	// Slot memories: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			valid_mem[wr_addr] <= wr_bit;
		end
		if (key_we) begin
			key_mem[wr_addr] <= key_q;
		end
		rd_valid_q <= valid_mem[rd_addr];
		rd_key_q <= key_mem[rd_addr];
	end

	assign rsp_valid = out_valid_q;
	assign status = status_q;
	assign slot_index = slot_q;
	assign probe_count = probes_out_q;

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || rsp_ready))
		else $error("Response register overwritten while still held.");

	a_no_rsp_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_INIT |-> !out_valid_q)
		else $error("Response presented during the start-up clearing pass.");

	a_insert_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (state_q == B_PROBE && !rd_valid_q && kind_q == KIND_INSERT))
		else $error("Key written into a slot that was not read as empty.");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_PROBE |-> probes_q < PROBE_MAX)
		else $error("Probe count ran past the table size.");

	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		pop_take |=> (state_q == B_PROBE || state_q == B_CLEAR))
		else $error("Popped request did not start a probe or a clear.");
`endif

endmodule

/* rtl/core/hash_table_probe_insert_unit.sv */
`timescale 1ns / 1ps
// Top level of the linear-probing key table: front end, request queue, probe engine.
// Depends on hpi_pkg, hpi_front, hpi_queue and hpi_back.
//
// Requests come in on req_valid/req_ready with op and search_key; one response per
// request leaves on rsp_valid/rsp_ready with status, slot_index and probe_count, in
// request order. A beat moves on a channel when its valid and ready are both high.
// The front end takes a new request only once it has pushed the last one: it steps
// through accept, multiply and sum, then, when TABLE_DEPTH is not a power of two, a
// remainder unit taking 4 hash bits a cycle, then push. A two-entry queue lets it
// run ahead. The probe engine reads one slot per cycle from a slot memory with one
// read and one write port, walking the chain from the home slot; a clear sweeps all
// TABLE_DEPTH slots empty. After reset the engine sweeps all TABLE_DEPTH slots empty,
// one per cycle; req_ready stays low until that sweep is done. The response sits in
// an output register; a stalled receiver holds the engine, while the front end and
// queue keep filling until the queue is full.
module hash_table_probe_insert_unit import hpi_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int SLOT_W = $clog2(TABLE_DEPTH),
	localparam int PROBE_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         op,
	input  logic [63:0]        search_key,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [PROBE_W-1:0] probe_count
);

	logic init_done;
	logic push_valid, push_ready;
	req_t push_req;
	logic [SLOT_W-1:0] push_home;
	logic pop_valid, pop_ready;
	req_t pop_req;
	logic [SLOT_W-1:0] pop_home;

	hpi_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.op         (op),
		.search_key (search_key),
		.init_done  (init_done),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.push_home  (push_home)
	);

	hpi_queue #(
		.SLOT_W(SLOT_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.push_home  (push_home),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_req    (pop_req),
		.pop_home   (pop_home)
	);

	hpi_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_req     (pop_req),
		.pop_home    (pop_home),
		.init_done   (init_done),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.slot_index  (slot_index),
		.probe_count (probe_count)
	);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for hash_table_probe_insert_unit: a directed table of requests,
// then random traffic checked against a mirror of the slot table kept in the bench.
// Depends on hpi_pkg and the RTL of the unit.
module tb_top;
	import hpi_pkg::*;

	localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
	localparam int SLOT_W = $clog2(TBL_DEPTH);
	localparam int PROBE_W = $clog2(TBL_DEPTH + 1);
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SCRIPT_LEN = 24;
	localparam int MIXED_ITEMS = 520;
	localparam int CLOSING_ITEMS = 150;
	localparam int FULL_ITEMS = 24;

	typedef struct packed {
		logic [2:0] status;
		logic [SLOT_W-1:0] slot;
		logic [PROBE_W-1:0] probes;
	} outcome_t;

	typedef struct packed {
		logic [1:0] op;
		logic [63:0] key;
		logic typed;
		outcome_t want;
	} script_row_t;

	// Rows with typed set carry a result that is obvious from the table contents; the
	// rest are checked against the mirror.
	localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
		'{OP_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, '{ST_NOT_FOUND, '0, '0}},
		'{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_NOT_FOUND, '0, '0}},
		'{OP_SPARE,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_NOT_FOUND, '0, '0}},
		'{OP_INSERT, 64'h0000_0000_0000_0000, 1'b1, '{ST_INSERTED, '0, '0}},
		'{OP_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, '{ST_FOUND, '0, '0}},
		'{OP_INSERT, 64'h0000_0000_0000_0000, 1'b1, '{ST_FOUND, '0, '0}},
		'{OP_SPARE,  64'h0000_0000_0000_0000, 1'b1, '{ST_FOUND, '0, '0}},
		'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{OP_INSERT, 64'h8000_0000_0000_0000, 1'b0, '0},
		'{OP_INSERT, 64'h0000_0001_0000_0000, 1'b0, '0},
		'{OP_INSERT, 64'h0000_0002_0000_0000, 1'b0, '0},
		'{OP_INSERT, 64'h0000_0000_0000_0001, 1'b0, '0},
		'{OP_LOOKUP, 64'h5555_5555_5555_5555, 1'b0, '0},
		'{OP_SPARE,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{OP_INSERT, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
		'{OP_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_CLEARED, '0, '0}},
		'{OP_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, '{ST_NOT_FOUND, '0, '0}},
		'{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_NOT_FOUND, '0, '0}},
		'{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{OP_CLEAR,  64'h0000_0000_0000_0000, 1'b1, '{ST_CLEARED, '0, '0}},
		'{OP_INSERT, 64'h0000_0000_0000_0000, 1'b1, '{ST_INSERTED, '0, '0}},
		'{OP_CLEAR,  64'h0123_4567_89AB_CDEF, 1'b1, '{ST_CLEARED, '0, '0}}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic [1:0] op;
	logic [63:0] search_key;
	logic rsp_valid;
	logic rsp_ready;
	logic [2:0] status;
	logic [SLOT_W-1:0] slot_index;
	logic [PROBE_W-1:0] probe_count;

	bit mirror_valid [TBL_DEPTH];
	logic [63:0] mirror_key [TBL_DEPTH];
	logic [63:0] stored_keys [$];
	int occupied = 0;
	outcome_t expected_outcomes [$];
	int errors = 0;
	int sent = 0;
	int stall_odds = 30;
	int idle_cycles = 0;
	int status_seen [5] = '{0, 0, 0, 0, 0};

	hash_table_probe_insert_unit #(
		.TABLE_DEPTH(TBL_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.op(op),
		.search_key(search_key),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.slot_index(slot_index),
		.probe_count(probe_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [SLOT_W-1:0] home_of(input logic [63:0] k);
		logic [63:0] h;
		h = k ^ (k >> HASH_SHIFT);
		h = h * HASH_MULT;
		h = h ^ (h >> HASH_SHIFT);
		return SLOT_W'(h % TBL_DEPTH);
	endfunction

	// Walks the mirror exactly as the engine should and applies any insert or clear.
	function automatic outcome_t probe_table(input logic [1:0] o, input logic [63:0] k);
		outcome_t res;
		int idx;
		int steps;
		res = '0;
		if (o == OP_CLEAR) begin
			for (int i = 0; i < TBL_DEPTH; i++)
				mirror_valid[i] = 1'b0;
			stored_keys.delete();
			occupied = 0;
			res.status = ST_CLEARED;
			return res;
		end
		idx = int'(home_of(k));
		steps = 0;
		res.status = ST_NOT_FOUND;
		while (mirror_valid[idx]) begin
			if (mirror_key[idx] == k) begin
				res.status = ST_FOUND;
				res.slot = SLOT_W'(idx);
				res.probes = PROBE_W'(steps);
				return res;
			end
			idx = (idx + 1) % TBL_DEPTH;
			steps++;
			if (steps >= TBL_DEPTH) begin
				res.status = (o == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
				res.probes = PROBE_W'(steps);
				return res;
			end
		end
		res.probes = PROBE_W'(steps);
		if (o == OP_INSERT) begin
			mirror_valid[idx] = 1'b1;
			mirror_key[idx] = k;
			stored_keys.push_back(k);
			occupied++;
			res.status = ST_INSERTED;
			res.slot = SLOT_W'(idx);
		end
		return res;
	endfunction

	function automatic logic [63:0] fresh_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: k = 64'd1 << $urandom_range(0, 63);
			1: k = ~(64'd1 << $urandom_range(0, 63));
			default: ;
		endcase
		return k;
	endfunction

	function automatic logic [63:0] known_key();
		if (stored_keys.size() == 0)
			return fresh_key();
		return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
	endfunction

	task automatic issue(input logic [1:0] o, input logic [63:0] k, input logic typed,
			input outcome_t want);
		outcome_t predicted;
		if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		search_key <= k;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predicted = probe_table(o, k);
		expected_outcomes.push_back(typed ? want : predicted);
		sent++;
	endtask

	task automatic mixed_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			issue(OP_INSERT, fresh_key(), 1'b0, '0);
		else if (pick < 50)
			issue(OP_INSERT, known_key(), 1'b0, '0);
		else if (pick < 75)
			issue(OP_LOOKUP, known_key(), 1'b0, '0);
		else if (pick < 90)
			issue(OP_LOOKUP, fresh_key(), 1'b0, '0);
		else if (pick < 97)
			issue(OP_SPARE, pick[0] ? known_key() : fresh_key(), 1'b0, '0);
		else
			issue(OP_CLEAR, fresh_key(), 1'b0, '0);
	endtask

	// Waits on a clock edge first, so valid is never lowered and raised in one step.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (expected_outcomes.size() != 0);
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		op <= OP_LOOKUP;
		search_key <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++)
			issue(SCRIPT[i].op, SCRIPT[i].key, SCRIPT[i].typed, SCRIPT[i].want);

		// Mixed traffic at light to moderate load, alternating idling and full rate.
		for (int i = 0; i < MIXED_ITEMS; i++) begin
			stall_odds = ((i / 100) % 2 == 0) ? 30 : 0;
			mixed_item();
		end

		// Let everything in flight come back, clear the table, then fill it to the last slot so
		// that probe chains grow long and wrap past the table end.
		drain();
		stall_odds = 20;
		issue(OP_CLEAR, fresh_key(), 1'b1, '{ST_CLEARED, '0, '0});
		while (occupied < TBL_DEPTH) begin
			if ($urandom_range(0, 9) == 0)
				issue(OP_LOOKUP, known_key(), 1'b0, '0);
			else
				issue(OP_INSERT, fresh_key(), 1'b0, '0);
		end

		// Table is full: misses and new inserts walk every slot.
		stall_odds = 30;
		for (int i = 0; i < FULL_ITEMS; i++) begin
			case (i % 6)
				0, 1: issue(OP_LOOKUP, fresh_key(), 1'b0, '0);
				2, 3: issue(OP_INSERT, fresh_key(), 1'b0, '0);
				4: issue(OP_INSERT, known_key(), 1'b0, '0);
				default: issue(OP_SPARE, i[1] ? known_key() : fresh_key(), 1'b0, '0);
			endcase
		end
		issue(OP_CLEAR, fresh_key(), 1'b1, '{ST_CLEARED, '0, '0});

		stall_odds = 0;
		for (int i = 0; i < CLOSING_ITEMS; i++)
			mixed_item();

		drain();
		repeat (TBL_DEPTH + 64) @(posedge clk);

		$display("Sent %0d requests: directed table, mixed traffic, a fill to full occupancy",
			sent);
		$display("and full-table walks; saw %0d found, %0d inserted, %0d not found, %0d full, %0d cleared.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		rsp_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: response beat with nothing expected: status %0d slot %0d probes %0d",
					$time, status, slot_index, probe_count);
				errors++;
			end else begin
				want = expected_outcomes.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d, actual %0d", $time, want.status, status);
					errors++;
				end
				if (slot_index !== want.slot) begin
					$display("%0t: slot_index expected %0d, actual %0d", $time, want.slot,
						slot_index);
					errors++;
				end
				if (probe_count !== want.probes) begin
					$display("%0t: probe_count expected %0d, actual %0d", $time, want.probes,
						probe_count);
					errors++;
				end
				if (want.status <= ST_CLEARED)
					status_seen[int'(want.status)]++;
			end
		end
	end

	// Ends a hung run: no beat on either channel for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d responses outstanding", $time,
				idle_cycles, expected_outcomes.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

/* filelist.f */
rtl/core/hpi_pkg.sv
rtl/core/hpi_front.sv
rtl/core/hpi_queue.sv
rtl/core/hpi_back.sv
rtl/core/hash_table_probe_insert_unit.sv
sim/tb_top.sv
